/* rtl/core/rthh_pkg.sv */
`default_nettype none
package rthh_pkg;
    localparam int ANGLE_FRAC_BITS_DEF = 12;
    localparam int ACC_BITS = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int XY_W = 33;
    localparam int Z_W = 34;
    localparam logic [20:0] SQRT3_Q20 = 21'd1816187;
    localparam longint RAD2DEG_Q24 = 64'd961263669;

    typedef logic signed [XY_W-1:0] t_xy;
    typedef logic signed [Z_W-1:0] t_z;

    typedef struct packed {
        logic       grey;
        logic       neg_side;
        logic [8:0] deg;
    } t_tag;

    function automatic t_z atan_step(input int i);
        t_z v;
        begin
            case (i)
                0: v = 34'sd754974720;
                1: v = 34'sd445687602;
                2: v = 34'sd235489088;
                3: v = 34'sd119537938;
                4: v = 34'sd60000934;
                5: v = 34'sd30029717;
                6: v = 34'sd15018523;
                7: v = 34'sd7509720;
                8: v = 34'sd3754917;
                9: v = 34'sd1877466;
                10: v = 34'sd938734;
                11: v = 34'sd469367;
                default: v = Z_W'((RAD2DEG_Q24 + (64'd1 << (i - 1))) >> i);
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

/* rtl/core/rthh_if.sv */
`default_nettype none
interface rthh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

interface rthh_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] hue_degrees;
    logic [7:0] hue_byte;
    logic       achromatic;
    modport source (output valid, hue_degrees, hue_byte, achromatic, input ready);
    modport sink (input valid, hue_degrees, hue_byte, achromatic, output ready);
endinterface
`default_nettype wire

/* rtl/core/rthh_cordic_stage.sv */
`default_nettype none
// One vectoring micro-rotation, registered, with its own valid bit.
module rthh_cordic_stage #(
    parameter int STEP = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire rthh_pkg::t_xy   i_x,
    input  wire rthh_pkg::t_xy   i_y,
    input  wire rthh_pkg::t_z    i_z,
    input  wire logic            i_hold,
    input  wire rthh_pkg::t_tag  i_tag,
    output logic                 o_valid,
    output rthh_pkg::t_xy        o_x,
    output rthh_pkg::t_xy        o_y,
    output rthh_pkg::t_z         o_z,
    output logic                 o_hold,
    output rthh_pkg::t_tag       o_tag
);
    localparam rthh_pkg::t_z A = rthh_pkg::atan_step(STEP);
    rthh_pkg::t_xy n_x, n_y;
    rthh_pkg::t_z  n_z;
    logic r_valid;

    // The arithmetic shift rounds toward minus infinity, as the rotation needs.
    always_comb begin
        if (i_hold) begin
            n_x = i_x;
            n_y = i_y;
            n_z = i_z;
        end else if (i_y > 0) begin
            n_x = i_x + (i_y >>> STEP);
            n_y = i_y - (i_x >>> STEP);
            n_z = i_z + A;
        end else begin
            n_x = i_x - (i_y >>> STEP);
            n_y = i_y + (i_x >>> STEP);
            n_z = i_z - A;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= n_x;
            o_y <= n_y;
            o_z <= n_z;
            o_hold <= i_hold;
            o_tag <= i_tag;
        end
    end
    assign o_valid = r_valid;
endmodule
`default_nettype wire

/* rtl/core/rthh_finish.sv */
`default_nettype none
// Clamps and rounds the angle, forms hue in whole degrees, registered.
module rthh_finish #(
    parameter int ANGLE_FRAC_BITS = rthh_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire rthh_pkg::t_z   i_z,
    input  wire logic           i_hold,
    input  wire rthh_pkg::t_tag i_tag,
    output rthh_pkg::t_tag      o_tag
);
    localparam int SH = rthh_pkg::ACC_BITS - ANGLE_FRAC_BITS;
    localparam int HW = 9 + ANGLE_FRAC_BITS + 1;
    localparam rthh_pkg::t_z TOP = rthh_pkg::t_z'(180) <<< rthh_pkg::ACC_BITS;
    rthh_pkg::t_z zc, th;
    logic signed [HW-1:0] hue;
    logic [8:0] deg;
    rthh_pkg::t_tag n_tag;

    always_comb begin
        zc = i_z;
        if (!i_hold) begin
            if (zc < 0) zc = '0;
            if (zc > TOP) zc = TOP;
        end
        th = (zc + (rthh_pkg::t_z'(1) <<< (SH - 1))) >>> SH;
        if (i_tag.neg_side) begin
            hue = (HW'(360) <<< ANGLE_FRAC_BITS) - HW'(th);
        end else begin
            hue = HW'(th);
        end
        if (hue < 0) hue = '0;
        if ((hue >>> ANGLE_FRAC_BITS) > 359) begin
            deg = 9'd359;
        end else begin
            deg = 9'(hue >>> ANGLE_FRAC_BITS);
        end
        n_tag = i_tag;
        n_tag.deg = i_tag.grey ? 9'd0 : deg;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_tag <= n_tag;
    end
endmodule
`default_nettype wire

/* rtl/core/rgb_to_hsi_hue_core.sv */
`default_nettype none
// Path: an accepted request passes through the registered stages in order until its result
// can be taken (seed, 24 rotations, finish, output).
// Throughput: one request per cycle; the whole pipeline advances when the output
// stage is free or being drained, so a stall holds every stage in place.
// Reset: i_rst_n is synchronous, active low, and clears every valid bit;
// payload registers are not reset.
module rgb_to_hsi_hue_core #(
    parameter int ANGLE_FRAC_BITS = rthh_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rthh_in_if.sink   i_pix,
    rthh_out_if.source o_hue
);
    localparam int N = rthh_pkg::CORDIC_STEPS;

    // One enable for every stage: the pipe moves unless the output holds a
    // result that is not being taken.
    logic en;
    assign en = !o_hue.valid || o_hue.ready;
    assign i_pix.ready = en;

    // Stage 0: products that seed the CORDIC vector, plus the axis and
    // left-half-plane handling.
    logic           r_v0;
    rthh_pkg::t_xy  r_x0, r_y0;
    rthh_pkg::t_z   r_z0;
    logic           r_h0;
    rthh_pkg::t_tag r_t0;
    rthh_pkg::t_xy  n_x0, n_y0, xs, ys;
    rthh_pkg::t_z   n_z0;
    logic           n_h0;
    rthh_pkg::t_tag n_t0;
    logic [7:0]     d_gb;

    always_comb begin
        d_gb = (i_pix.green >= i_pix.blue) ? i_pix.green - i_pix.blue
                                           : i_pix.blue - i_pix.green;
        xs = (rthh_pkg::t_xy'({1'b0, i_pix.red, 1'b0}) - rthh_pkg::t_xy'(i_pix.green)
              - rthh_pkg::t_xy'(i_pix.blue)) <<< 20;
        ys = rthh_pkg::t_xy'(29'(d_gb) * rthh_pkg::SQRT3_Q20);
        n_t0.grey = (i_pix.red == i_pix.green) && (i_pix.green == i_pix.blue);
        n_t0.neg_side = i_pix.blue > i_pix.green;
        n_t0.deg = '0;
        n_h0 = 1'b0;
        n_x0 = xs;
        n_y0 = ys;
        n_z0 = '0;
        if (ys == 0) begin
            // On the axis the angle is exact and the iterations are bypassed.
            n_h0 = 1'b1;
            n_z0 = (xs >= 0) ? '0 : (rthh_pkg::t_z'(180) <<< rthh_pkg::ACC_BITS);
        end else if (xs < 0) begin
            n_x0 = ys;
            n_y0 = -xs;
            n_z0 = rthh_pkg::t_z'(90) <<< rthh_pkg::ACC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0 <= n_x0;
            r_y0 <= n_y0;
            r_z0 <= n_z0;
            r_h0 <= n_h0;
            r_t0 <= n_t0;
        end
    end

    // CORDIC chain: one micro-rotation per stage.
    logic           v [N+1];
    rthh_pkg::t_xy  x [N+1];
    rthh_pkg::t_xy  y [N+1];
    rthh_pkg::t_z   z [N+1];
    logic           h [N+1];
    rthh_pkg::t_tag t [N+1];
    assign v[0] = r_v0;
    assign x[0] = r_x0;
    assign y[0] = r_y0;
    assign z[0] = r_z0;
    assign h[0] = r_h0;
    assign t[0] = r_t0;

    for (genvar s = 0; s < N; s++) begin : g_cordic
        rthh_cordic_stage #(.STEP(s)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(v[s]), .i_x(x[s]), .i_y(y[s]), .i_z(z[s]),
            .i_hold(h[s]), .i_tag(t[s]),
            .o_valid(v[s+1]), .o_x(x[s+1]), .o_y(y[s+1]), .o_z(z[s+1]),
            .o_hold(h[s+1]), .o_tag(t[s+1])
        );
    end

    // Rounding and hue formation.
    logic           r_vf;
    rthh_pkg::t_tag tf;
    rthh_finish #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_finish (
        .i_clk(i_clk), .i_en(en), .i_z(z[N]), .i_hold(h[N]), .i_tag(t[N]),
        .o_tag(tf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (en) begin
            r_vf <= v[N];
        end
    end

    // Output register: the byte scaling is floor(deg*255/360), done as a
    // multiply by the reciprocal 255*2^13/360 rounded up, exact for 0..359.
    logic        r_vo;
    logic [8:0]  r_deg;
    logic [7:0]  r_byte;
    logic        r_ach;
    logic [20:0] prod;
    assign prod = 21'(tf.deg) * 21'd5803;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_vf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_deg <= tf.deg;
            r_byte <= prod[20:13];
            r_ach <= tf.grey;
        end
    end

    assign o_hue.valid = r_vo;
    assign o_hue.hue_degrees = r_deg;
    assign o_hue.hue_byte = r_byte;
    assign o_hue.achromatic = r_ach;
endmodule
`default_nettype wire
